[src/lmc_pkg.sv]
// Shared constants and types for the letter multiset containment block.
// No dependencies; every other file in src refers to this package by scope.
package lmc_pkg;

  localparam int LETTERS    = 26;
  localparam int COUNT_BITS = 8;
  localparam int INDEX_W    = 16;
  localparam int IDX_W      = (LETTERS > 1) ? $clog2(LETTERS) : 1;

  localparam logic [7:0] CH_A   = 8'h61;
  localparam logic [7:0] CH_Z   = 8'h7A;
  localparam logic [7:0] CH_TAB = 8'h09;

  typedef logic [COUNT_BITS-1:0] count_t;
  localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

  // Decoded character handed from the front end to the counter bank
  typedef struct packed {
    logic               cand;    // target bank: 1 = candidate, 0 = query
    logic               clr;     // first character of a word: clear the bank
    logic               inc;     // count the letter at idx
    logic [IDX_W-1:0]   idx;
    logic               report;  // last character of a candidate
    logic [INDEX_W-1:0] index;
  } cmd_t;

  typedef struct packed {
    logic               match;
    logic [INDEX_W-1:0] index;
  } res_t;

endpackage

[src/lmc_front.sv]
// Front end: takes input beats, tracks word boundaries, tab state and the
// candidate number, and emits one decoded command per beat. Uses lmc_pkg.
module lmc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_func,
  input  logic [7:0]          in_char_code,
  input  logic                in_last,
  input  logic                q_full,
  output logic                q_push,
  output lmc_pkg::cmd_t       q_cmd
);

  logic                        word_started_r, word_started_nxt;
  logic                        tab_seen_r, tab_seen_nxt;
  logic [lmc_pkg::INDEX_W-1:0] cand_cnt_r, cand_cnt_nxt;

  logic       start;
  logic       tab_eff;
  logic [7:0] diff;
  logic       is_letter;

  assign q_push = in_push && !q_full;

  always_comb begin
    start     = !word_started_r;
    tab_eff   = start ? 1'b0 : tab_seen_r;
    diff      = in_char_code - lmc_pkg::CH_A;
    is_letter = (in_char_code >= lmc_pkg::CH_A) && (in_char_code <= lmc_pkg::CH_Z) &&
                (diff < 8'(lmc_pkg::LETTERS));

    q_cmd.cand   = in_func;
    q_cmd.clr    = start;
    q_cmd.inc    = !tab_eff && is_letter;
    q_cmd.idx    = diff[lmc_pkg::IDX_W-1:0];
    q_cmd.report = in_last && in_func;
    q_cmd.index  = cand_cnt_r;

    word_started_nxt = !in_last;
    if (in_last) begin
      tab_seen_nxt = 1'b0;
    end else if (!tab_eff && (in_char_code == lmc_pkg::CH_TAB)) begin
      tab_seen_nxt = 1'b1;
    end else begin
      tab_seen_nxt = tab_eff;
    end

    // a query start restarts numbering; a finished candidate advances it
    if (start && !in_func) begin
      cand_cnt_nxt = '0;
    end else if (in_last && in_func) begin
      cand_cnt_nxt = cand_cnt_r + 1'b1;
    end else begin
      cand_cnt_nxt = cand_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_started_r <= 1'b0;
      tab_seen_r     <= 1'b0;
      cand_cnt_r     <= '0;
    end else if (q_push) begin
      word_started_r <= word_started_nxt;
      tab_seen_r     <= tab_seen_nxt;
      cand_cnt_r     <= cand_cnt_nxt;
    end
  end

endmodule

[src/lmc_cmdq.sv]
// Two-entry command queue between the front end and the counter bank.
// Uses lmc_pkg::cmd_t.
module lmc_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lmc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output lmc_pkg::cmd_t pop_cmd
);

  lmc_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

endmodule

[src/lmc_back.sv]
// Back end: query and candidate letter counters, the containment compare and
// a two-entry result queue. Uses lmc_pkg.
module lmc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  lmc_pkg::cmd_t               q_cmd,
  output logic                        q_pop,
  input  logic                        out_pop,
  output logic                        out_empty,
  output logic                        out_match,
  output logic [lmc_pkg::INDEX_W-1:0] out_candidate_index
);

  lmc_pkg::count_t qry_r  [lmc_pkg::LETTERS];
  lmc_pkg::count_t cnd_r  [lmc_pkg::LETTERS];
  lmc_pkg::count_t qry_nxt[lmc_pkg::LETTERS];
  lmc_pkg::count_t cnd_nxt[lmc_pkg::LETTERS];
  logic            match;

  lmc_pkg::res_t res_r [2];
  lmc_pkg::res_t res_in;
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r;
  logic          res_push, res_pop;

  // hold the command while the result queue has no room
  assign q_pop    = !q_empty && (count_r != 2'd2);
  assign res_push = q_pop && q_cmd.report;
  assign res_pop  = out_pop && (count_r != 2'd0);

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < lmc_pkg::LETTERS; i++) begin
      qry_nxt[i] = (q_cmd.clr && !q_cmd.cand) ? '0 : qry_r[i];
      cnd_nxt[i] = (q_cmd.clr &&  q_cmd.cand) ? '0 : cnd_r[i];
      if (q_cmd.inc && (q_cmd.idx == lmc_pkg::IDX_W'(i))) begin
        if (q_cmd.cand) begin
          if (cnd_nxt[i] != lmc_pkg::COUNT_MAX) cnd_nxt[i] = cnd_nxt[i] + 1'b1;
        end else begin
          if (qry_nxt[i] != lmc_pkg::COUNT_MAX) qry_nxt[i] = qry_nxt[i] + 1'b1;
        end
      end
      if (cnd_nxt[i] > qry_nxt[i]) match = 1'b0;
    end
    res_in.match = match;
    res_in.index = q_cmd.index;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lmc_pkg::LETTERS; i++) begin
        qry_r[i] <= '0;
        cnd_r[i] <= '0;
      end
    end else if (q_pop) begin
      for (int i = 0; i < lmc_pkg::LETTERS; i++) begin
        qry_r[i] <= qry_nxt[i];
        cnd_r[i] <= cnd_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (res_push) wr_ptr_r <= !wr_ptr_r;
      if (res_pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) res_r[wr_ptr_r] <= res_in;
  end

  assign out_empty           = (count_r == 2'd0);
  assign out_match           = res_r[rd_ptr_r].match;
  assign out_candidate_index = res_r[rd_ptr_r].index;

endmodule

[src/letter_multiset_containment_top.sv]
// Letter multiset containment: one character beat per cycle unless in_full stalls.
// A candidate's result reaches the result ports after its last character is
// accepted, via the command queue, then counter bank into result queue.
// Synchronous active-low reset clears all letter counters, word and tab state,
// the candidate number and both queues; the block is ready the cycle after.
// Depends on lmc_pkg, lmc_front, lmc_cmdq and lmc_back.
module letter_multiset_containment_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_func,
  input  logic [7:0]                  in_char_code,
  input  logic                        in_last,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_match,
  output logic [lmc_pkg::INDEX_W-1:0] out_candidate_index,
  output logic                        out_last_result
);

  logic          q_push, q_full, q_pop, q_empty;
  lmc_pkg::cmd_t push_cmd, pop_cmd;

  assign in_full         = q_full;
  assign out_last_result = 1'b1;

  lmc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_func      (in_func),
    .in_char_code (in_char_code),
    .in_last      (in_last),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  lmc_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_cmd  (pop_cmd)
  );

  lmc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_cmd               (pop_cmd),
    .q_pop               (q_pop),
    .out_pop             (out_pop),
    .out_empty           (out_empty),
    .out_match           (out_match),
    .out_candidate_index (out_candidate_index)
  );

endmodule

[src/lmc_checker.sv]
// Port-level checks for letter_multiset_containment_top, attached by bind.
// Uses lmc_pkg for the index width.
module lmc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_full,
  input logic                        out_empty,
  input logic                        out_pop,
  input logic                        out_match,
  input logic [lmc_pkg::INDEX_W-1:0] out_candidate_index,
  input logic                        out_last_result
);

  // the result queue comes out of reset empty, the command queue not full
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // a result beat always closes its run
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_last_result)
    else $error("result beat without last_result");

  // a waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_match) &&
      $stable(out_candidate_index))
    else $error("waiting result changed");

  // no result can be shown in the first cycle out of reset
  a_no_early_result: assert property (@(posedge clk)
    !rst_n ##1 rst_n |-> out_empty)
    else $error("result shown straight out of reset");

endmodule

bind letter_multiset_containment_top lmc_checker u_lmc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_full             (in_full),
  .out_empty           (out_empty),
  .out_pop             (out_pop),
  .out_match           (out_match),
  .out_candidate_index (out_candidate_index),
  .out_last_result     (out_last_result)
);

[tb/tb_top.sv]
// Self-checking bench for letter_multiset_containment_top: streams query and
// candidate words and checks each result against a histogram predictor or typed values.
// Depends on lmc_pkg and the RTL under src; reads no files.
module tb_top;

  localparam logic FN_QUERY = 1'b0;
  localparam logic FN_CAND  = 1'b1;
  localparam int   QUIET_LIMIT = 4000;
  localparam int   RAND_GOAL   = 120;

  typedef struct packed {
    logic       cand;
    logic [7:0] ch;
    logic       lst;
    logic       typed;
    logic       t_match;
    logic [15:0] t_index;
  } row_t;

  // Directed words; typed verdicts only where obvious by hand
  localparam row_t PLAN [24] = '{
    '{FN_CAND,  "a",    1'b1, 1'b1, 1'b0, 16'd0},  // candidate before any query
    '{FN_QUERY, "a",    1'b0, 1'b0, 1'b0, 16'd0},
    '{FN_QUERY, "b",    1'b1, 1'b0, 1'b0, 16'd0},  // query end gives nothing
    '{FN_CAND,  "b",    1'b0, 1'b0, 1'b0, 16'd0},
    '{FN_CAND,  "a",    1'b1, 1'b1, 1'b1, 16'd0},
    '{FN_CAND,  "z",    1'b1, 1'b1, 1'b0, 16'd1},
    '{FN_CAND,  lmc_pkg::CH_TAB, 1'b0, 1'b0, 1'b0, 16'd0},  // tab as first character
    '{FN_CAND,  "z",    1'b1, 1'b1, 1'b1, 16'd2},
    '{FN_CAND,  8'h00,  1'b0, 1'b0, 1'b0, 16'd0},
    '{FN_CAND,  8'hFF,  1'b0, 1'b0, 1'b0, 16'd0},
    '{FN_CAND,  8'h41,  1'b0, 1'b0, 1'b0, 16'd0},
    '{FN_CAND,  8'h7B,  1'b0, 1'b0, 1'b0, 16'd0},
    '{FN_CAND,  8'h60,  1'b1, 1'b1, 1'b1, 16'd3},
    '{FN_CAND,  "a",    1'b0, 1'b0, 1'b0, 16'd0},
    '{FN_CAND,  "a",    1'b1, 1'b1, 1'b0, 16'd4},  // one letter too many
    '{FN_QUERY, "c",    1'b0, 1'b0, 1'b0, 16'd0},  // new query restarts numbering
    '{FN_CAND,  "d",    1'b0, 1'b0, 1'b0, 16'd0},  // func flips inside a word
    '{FN_QUERY, "e",    1'b1, 1'b0, 1'b0, 16'd0},
    '{FN_CAND,  "c",    1'b1, 1'b1, 1'b1, 16'd0},
    '{FN_CAND,  "e",    1'b0, 1'b0, 1'b0, 16'd0},
    '{FN_QUERY, "x",    1'b1, 1'b0, 1'b0, 16'd0},  // candidate word closed as query
    '{FN_CAND,  "x",    1'b0, 1'b0, 1'b0, 16'd0},
    '{FN_CAND,  lmc_pkg::CH_TAB, 1'b0, 1'b0, 1'b0, 16'd0},  // tab mid-word
    '{FN_CAND,  "q",    1'b1, 1'b0, 1'b0, 16'd0}
  };

  logic                        clk;
  logic                        rst_n        = 1'b0;
  logic                        in_push      = 1'b0;
  logic                        in_func      = 1'b0;
  logic [7:0]                  in_char_code = 8'h00;
  logic                        in_last      = 1'b0;
  logic                        out_pop      = 1'b0;
  logic                        in_full;
  logic                        out_empty;
  logic                        out_match;
  logic [lmc_pkg::INDEX_W-1:0] out_candidate_index;
  logic                        out_last_result;

  // Predictor state
  lmc_pkg::count_t             q_hist [lmc_pkg::LETTERS];
  lmc_pkg::count_t             c_hist [lmc_pkg::LETTERS];
  logic                        in_word;
  logic                        tab_hit;
  logic [lmc_pkg::INDEX_W-1:0] cand_no;

  lmc_pkg::res_t verdict_q [$];
  logic [7:0]    query_letters [$];
  int            push_idle_pct = 20;
  int            pop_idle_pct  = 59;
  int            mismatches    = 0;
  int            fed           = 0;
  int            quiet         = 0;

  letter_multiset_containment_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_func             (in_func),
    .in_char_code        (in_char_code),
    .in_last             (in_last),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_match           (out_match),
    .out_candidate_index (out_candidate_index),
    .out_last_result     (out_last_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    if (mismatches < 40) begin
      $display("mismatch on %s: got %0d, want %0d", what, got, want);
    end
    mismatches++;
  endtask

  // Advance the histograms by one character; give a verdict on a candidate's last
  task automatic spell_step(input logic cand, input logic [7:0] ch, input logic lst,
                            output logic made, output lmc_pkg::res_t v);
    int k;
    made = 1'b0;
    v    = '0;
    if (!in_word) begin
      for (k = 0; k < lmc_pkg::LETTERS; k++) begin
        if (cand) c_hist[k] = '0;
        else q_hist[k] = '0;
      end
      tab_hit = 1'b0;
      in_word = 1'b1;
      if (!cand) cand_no = '0;
    end
    if (!tab_hit) begin
      if (ch == lmc_pkg::CH_TAB) begin
        tab_hit = 1'b1;
      end else if (ch >= lmc_pkg::CH_A && ch <= lmc_pkg::CH_Z) begin
        k = int'(ch) - int'(lmc_pkg::CH_A);
        if (k < lmc_pkg::LETTERS) begin
          if (cand && c_hist[k] != lmc_pkg::COUNT_MAX) c_hist[k] = c_hist[k] + 1'b1;
          if (!cand && q_hist[k] != lmc_pkg::COUNT_MAX) q_hist[k] = q_hist[k] + 1'b1;
        end
      end
    end
    if (lst) begin
      in_word = 1'b0;
      tab_hit = 1'b0;
      if (cand) begin
        made    = 1'b1;
        v.match = 1'b1;
        for (k = 0; k < lmc_pkg::LETTERS; k++) begin
          if (c_hist[k] > q_hist[k]) v.match = 1'b0;
        end
        v.index = cand_no;
        cand_no = cand_no + 1'b1;
      end
    end
  endtask

  // Drive one beat, hold it until taken, then record the expected verdict
  task automatic feed_char(input logic f, input logic [7:0] ch, input logic lst,
                           input logic typed = 1'b0, input lmc_pkg::res_t given = '0);
    logic          made;
    lmc_pkg::res_t v;
    while ($urandom_range(99) < push_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_func      <= f;
    in_char_code <= ch;
    in_last      <= lst;
    @(posedge clk);
    while (in_full !== 1'b0) @(posedge clk);
    spell_step(f, ch, lst, made, v);
    if (made) verdict_q.push_back(typed ? given : v);
    fed++;
  endtask

  // Hold off the sender until every pending verdict has been popped
  task automatic drain;
    in_push <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  task automatic spell_word(input logic cand, input int n);
    logic [7:0] ch;
    logic       f;
    int         j;
    for (j = 0; j < n; j++) begin
      case ($urandom_range(15))
        0: ch = 8'($urandom_range(255));
        1: ch = lmc_pkg::CH_TAB;
        default: begin
          if (cand && query_letters.size() > 0 && $urandom_range(3) != 0)
            ch = query_letters[$urandom_range(query_letters.size() - 1)];
          else
            ch = 8'(int'(lmc_pkg::CH_A) + $urandom_range(25));
        end
      endcase
      f = ($urandom_range(31) == 0) ? !cand : cand;
      if (!cand) query_letters.push_back(ch);
      feed_char(f, ch, j == n - 1);
    end
  endtask

  task automatic random_rounds(input int goal);
    int stop;
    int rounds;
    stop   = fed + goal;
    rounds = 0;
    while (fed < stop) begin
      query_letters.delete();
      spell_word(FN_QUERY, $urandom_range(12, 1));
      repeat ($urandom_range(8)) spell_word(FN_CAND, $urandom_range(query_letters.size() + 2, 1));
      rounds++;
      if (rounds % 25 == 0) drain();
    end
  endtask

  // Result side: check each popped beat, then decide whether to stall
  always @(posedge clk) begin : rx
    lmc_pkg::res_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (verdict_q.size() == 0) begin
          report("unexpected result index", out_candidate_index, 16'd0);
        end else begin
          want = verdict_q.pop_front();
          if (out_match !== want.match) report("match", out_match, want.match);
          if (out_candidate_index !== want.index)
            report("candidate_index", out_candidate_index, want.index);
          if (out_last_result !== 1'b1) report("last_result", out_last_result, 16'd1);
        end
      end
      out_pop <= ($urandom_range(99) >= pop_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin : stim
    int            i;
    lmc_pkg::res_t given;
    for (i = 0; i < lmc_pkg::LETTERS; i++) begin
      q_hist[i] = '0;
      c_hist[i] = '0;
    end
    in_word = 1'b0;
    tab_hit = 1'b0;
    cand_no = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < $size(PLAN); i++) begin
      given.match = PLAN[i].t_match;
      given.index = PLAN[i].t_index;
      feed_char(PLAN[i].cand, PLAN[i].ch, PLAN[i].lst, PLAN[i].typed, given);
    end
    random_rounds(RAND_GOAL);
    drain();

    push_idle_pct = 59;
    pop_idle_pct  = 20;
    random_rounds(RAND_GOAL);
    drain();

    push_idle_pct = 0;
    pop_idle_pct  = 0;
    random_rounds(RAND_GOAL);

    // Saturation: 256 query a's hold at the maximum rather than wrapping to zero
    for (i = 0; i < 256; i++) feed_char(FN_QUERY, "a", i == 255);
    feed_char(FN_CAND, "a", 1'b1);
    for (i = 0; i < 257; i++) feed_char(FN_CAND, "a", i == 256);

    drain();
    repeat (8) @(posedge clk);
    if (verdict_q.size() != 0) report("verdicts left pending", 16'(verdict_q.size()), 16'd0);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[letter_multiset_containment_top.f]
src/lmc_pkg.sv
src/lmc_front.sv
src/lmc_cmdq.sv
src/lmc_back.sv
src/letter_multiset_containment_top.sv
src/lmc_checker.sv
tb/tb_top.sv
